### rtl/dlte_pkg.sv
// shared types, constants and fixed-point helpers of the dense layer training engine
package dlte_pkg;

    localparam int VW        = 16;
    localparam int FRAC      = VW - 4;
    localparam int ACC_W     = 40;
    localparam int MAX_RES   = 16;
    localparam int OPA_W     = 18;
    localparam int OPB_W     = 24;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int LO_BITS   = 20;
    localparam int UPD_SHIFT = 16 + FRAC;
    localparam int DELTA_W   = 30;

    typedef logic signed [VW-1:0]     t_val;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic [1:0] {
        ACT_LOAD_W = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_FWD    = 2'd2,
        ACT_BWD    = 2'd3
    } t_action;

    localparam logic KIND_FWD = 1'b0;
    localparam logic KIND_BWD = 1'b1;

    typedef struct packed {
        t_action    action;
        logic [3:0] example;
        logic [3:0] row;
        logic [3:0] col;
        t_val       value;
        logic       row_end;
        logic       batch_end;
    } t_in_word;

    typedef struct packed {
        logic       kind;
        logic [3:0] example_res;
        logic [3:0] index;
        t_val       value_res;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic                    mul_en;
        logic signed [OPA_W-1:0] op_a;
        logic signed [OPB_W-1:0] op_b;
    } t_mac_ctl;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWD_RD,
        ST_FWD_MUL,
        ST_FWD_ACC,
        ST_FOUT_RD,
        ST_FOUT_CALC,
        ST_FOUT_PUT,
        ST_BWD_RD,
        ST_BWD_MUL,
        ST_BWD_WG,
        ST_BWD_IG,
        ST_BIAS_RD,
        ST_BIAS_MUL,
        ST_BIAS_ACC,
        ST_BOUT_RD,
        ST_BOUT_CALC,
        ST_BOUT_PUT,
        ST_UPD_RD,
        ST_UPD_LO,
        ST_UPD_HI,
        ST_UPD_SUM,
        ST_UPD_WR
    } t_state;

    localparam logic signed [63:0] ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam logic signed [63:0] ACC_LO = -ACC_HI - 64'sd1;
    localparam logic signed [63:0] VAL_HI = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam logic signed [63:0] VAL_LO = -VAL_HI - 64'sd1;
    localparam logic signed [OPB_W-1:0] BIAS_SCALE = OPB_W'(64'sd1 <<< FRAC);

    function automatic t_acc sat_acc(input logic signed [63:0] x);
        t_acc r;
        if (x > ACC_HI) begin
            r = ACC_W'(ACC_HI);
        end else if (x < ACC_LO) begin
            r = ACC_W'(ACC_LO);
        end else begin
            r = ACC_W'(x);
        end
        return r;
    endfunction

    function automatic t_val sat_val(input logic signed [63:0] x);
        t_val r;
        if (x > VAL_HI) begin
            r = VW'(VAL_HI);
        end else if (x < VAL_LO) begin
            r = VW'(VAL_LO);
        end else begin
            r = VW'(x);
        end
        return r;
    endfunction

    // round half up at scale 2^FRAC, then saturate
    function automatic t_val rescale(input logic signed [63:0] x);
        logic signed [63:0] r;
        r = (x + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        return sat_val(r);
    endfunction

endpackage

### rtl/dense_layer_train_engine_top.sv
// top level of the dense layer training engine: sequencer, state memories and shared mac
// Fully connected layer in signed Q4.12 with one shared multiplier stepped by a sequencer;
// the input stalls while an item is worked on. Weight and bias loads are written as they are
// accepted. A forward feature is multiplied into the sum of each output; when it ends a row,
// each sum is rescaled with its bias and put out. A backward gradient adds into the weight
// and input gradient sums of each input and into its bias gradient; a row end puts out the
// rescaled input gradients, and a batch end updates all 2^(IW+OW) weights and 2^OW biases,
// where IW and OW are the index widths of IN_SIZE and OUT_SIZE. After reset a clearing pass
// over all 2^(IW+OW) addresses runs before the first word is taken; learning_rate may be
// written during it. A result word waits in an output register, so a stalled output does
// not block the sequencer until the next result is ready.
module dense_layer_train_engine_top import dlte_pkg::*; #(
    parameter int IN_SIZE    = 16,
    parameter int OUT_SIZE   = 16,
    parameter int BATCH_SIZE = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    localparam int IW = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
    localparam int OW = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
    localparam int BW = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
    localparam int CW = IW + OW;
    localparam int OUT_CNT = (OUT_SIZE < MAX_RES) ? OUT_SIZE : MAX_RES;
    localparam int IN_CNT  = (IN_SIZE < MAX_RES) ? IN_SIZE : MAX_RES;
    localparam logic [CW-1:0] OUT_LAST  = CW'(OUT_SIZE - 1);
    localparam logic [CW-1:0] IN_LAST   = CW'(IN_SIZE - 1);
    localparam logic [CW-1:0] OUT_RLAST = CW'(OUT_CNT - 1);
    localparam logic [CW-1:0] IN_RLAST  = CW'(IN_CNT - 1);
    localparam logic [CW-1:0] BIAS_LAST = CW'((1 << OW) - 1);
    localparam logic [CW-1:0] ALL_LAST  = {CW{1'b1}};

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_upd_bias, n_upd_bias;
    logic [15:0] r_eta;

    logic [3:0] r_ex, r_col;
    t_val r_val;
    logic r_row_end, r_batch_end;

    t_val r_res;
    logic signed [PROD_W-1:0] r_plo;
    logic signed [DELTA_W-1:0] r_delta;

    logic r_out_valid;
    t_out_word r_out_word;

    logic accept, busy, emit, advance, out_load;
    logic fwd_col_ok, bwd_col_ok, ex_ok;

    // memory ports
    logic          w_we, w_re, b_we, b_re, bg_we, bg_re, fs_we, fs_re;
    logic          ig_we, ig_re, wg_we, wg_re, sv_we, sv_re;
    logic [CW-1:0] w_waddr, w_raddr, wg_waddr, wg_raddr;
    logic [OW-1:0] b_waddr, bg_addr;
    logic [BW+IW-1:0] sv_waddr, sv_raddr;
    t_val          w_wdata, b_wdata, w_rd, b_rd, sv_rd;
    t_acc          bg_wdata, fs_wdata, ig_wdata, wg_wdata;
    t_acc          bg_rd, fs_rd, ig_rd, wg_rd;
    logic [CW-1:0] a_fwd, a_bwd, a_load;

    t_mac_ctl mac_ctl;
    t_acc     mac_acc_in, mac_acc;
    t_prod    mac_prod;
    t_acc     upd_g;
    t_val     upd_w, upd_new, x_val;
    t_out_word out_word;

    function automatic logic fwd_col_ok_row(input t_in_word w);
        return (32'(w.row) < IN_SIZE);
    endfunction

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign busy       = r_out_valid && i_out_stall;
    assign emit       = (32'(r_cnt) < MAX_RES);
    assign advance    = !(emit && busy);
    assign fwd_col_ok = (32'(i_in_word.col) < IN_SIZE);
    assign bwd_col_ok = (32'(i_in_word.col) < OUT_SIZE);
    assign ex_ok      = (32'(r_ex) < BATCH_SIZE);

    assign a_fwd  = {IW'(r_col), r_cnt[OW-1:0]};
    assign a_bwd  = {r_cnt[IW-1:0], OW'(r_col)};
    assign a_load = {IW'(i_in_word.row), OW'(i_in_word.col)};

    assign x_val   = ex_ok ? sv_rd : '0;
    assign upd_g   = r_upd_bias ? bg_rd : wg_rd;
    assign upd_w   = r_upd_bias ? b_rd : w_rd;
    assign upd_new = sat_val(64'(upd_w) - 64'(r_delta));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == ALL_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_word.action)
                        ACT_FWD: begin
                            if (fwd_col_ok) n_state = ST_FWD_RD;
                            else if (i_in_word.row_end) n_state = ST_FOUT_RD;
                        end
                        ACT_BWD: begin
                            if (bwd_col_ok) n_state = ST_BWD_RD;
                            else if (i_in_word.row_end) n_state = ST_BOUT_RD;
                            else if (i_in_word.batch_end) n_state = ST_UPD_RD;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FWD_RD:  n_state = ST_FWD_MUL;
            ST_FWD_MUL: n_state = ST_FWD_ACC;
            ST_FWD_ACC: begin
                if (r_cnt != OUT_LAST) n_state = ST_FWD_RD;
                else if (r_row_end) n_state = ST_FOUT_RD;
                else n_state = ST_IDLE;
            end
            ST_FOUT_RD:   n_state = ST_FOUT_CALC;
            ST_FOUT_CALC: n_state = ST_FOUT_PUT;
            ST_FOUT_PUT: begin
                if (advance) n_state = (r_cnt == OUT_LAST) ? ST_IDLE : ST_FOUT_RD;
            end
            ST_BWD_RD:  n_state = ST_BWD_MUL;
            ST_BWD_MUL: n_state = ST_BWD_WG;
            ST_BWD_WG:  n_state = ST_BWD_IG;
            ST_BWD_IG:  n_state = (r_cnt == IN_LAST) ? ST_BIAS_RD : ST_BWD_RD;
            ST_BIAS_RD:  n_state = ST_BIAS_MUL;
            ST_BIAS_MUL: n_state = ST_BIAS_ACC;
            ST_BIAS_ACC: begin
                if (r_row_end) n_state = ST_BOUT_RD;
                else if (r_batch_end) n_state = ST_UPD_RD;
                else n_state = ST_IDLE;
            end
            ST_BOUT_RD:   n_state = ST_BOUT_CALC;
            ST_BOUT_CALC: n_state = ST_BOUT_PUT;
            ST_BOUT_PUT: begin
                if (advance) begin
                    if (r_cnt != IN_LAST) n_state = ST_BOUT_RD;
                    else if (r_batch_end) n_state = ST_UPD_RD;
                    else n_state = ST_IDLE;
                end
            end
            ST_UPD_RD:  n_state = ST_UPD_LO;
            ST_UPD_LO:  n_state = ST_UPD_HI;
            ST_UPD_HI:  n_state = ST_UPD_SUM;
            ST_UPD_SUM: n_state = ST_UPD_WR;
            ST_UPD_WR: begin
                if (r_upd_bias && (r_cnt == BIAS_LAST)) n_state = ST_IDLE;
                else n_state = ST_UPD_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // counters, memory controls and mac operands
    always_comb begin
        n_cnt      = r_cnt;
        n_upd_bias = r_upd_bias;
        out_load   = 1'b0;

        w_we = 1'b0; w_re = 1'b0; b_we = 1'b0; b_re = 1'b0;
        bg_we = 1'b0; bg_re = 1'b0; fs_we = 1'b0; fs_re = 1'b0;
        ig_we = 1'b0; ig_re = 1'b0; wg_we = 1'b0; wg_re = 1'b0;
        sv_we = 1'b0; sv_re = 1'b0;

        w_waddr  = r_cnt;
        w_raddr  = r_cnt;
        w_wdata  = '0;
        b_waddr  = r_cnt[OW-1:0];
        b_wdata  = '0;
        bg_addr  = r_cnt[OW-1:0];
        bg_wdata = '0;
        fs_wdata = '0;
        ig_wdata = '0;
        wg_waddr = r_cnt;
        wg_raddr = r_cnt;
        wg_wdata = '0;
        sv_waddr = {BW'(i_in_word.example), IW'(i_in_word.col)};
        sv_raddr = {BW'(r_ex), r_cnt[IW-1:0]};

        mac_ctl.mul_en = 1'b0;
        mac_ctl.op_a   = OPA_W'(r_val);
        mac_ctl.op_b   = OPB_W'(w_rd);
        mac_acc_in     = fs_rd;

        case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1; b_we = 1'b1; bg_we = 1'b1; fs_we = 1'b1;
                ig_we = 1'b1; wg_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
            end
            ST_IDLE: begin
                n_cnt      = '0;
                n_upd_bias = 1'b0;
                if (accept) begin
                    case (i_in_word.action)
                        ACT_LOAD_W: begin
                            w_we    = fwd_col_ok_row(i_in_word) && bwd_col_ok;
                            w_waddr = a_load;
                            w_wdata = i_in_word.value;
                        end
                        ACT_LOAD_B: begin
                            b_we    = bwd_col_ok;
                            b_waddr = OW'(i_in_word.col);
                            b_wdata = i_in_word.value;
                        end
                        ACT_FWD: begin
                            sv_we = fwd_col_ok && (32'(i_in_word.example) < BATCH_SIZE);
                        end
                        default: ;
                    endcase
                end
            end
            ST_FWD_RD: begin
                w_re    = 1'b1;
                w_raddr = a_fwd;
                fs_re   = 1'b1;
            end
            ST_FWD_MUL: begin
                mac_ctl.mul_en = 1'b1;
            end
            ST_FWD_ACC: begin
                fs_we    = 1'b1;
                fs_wdata = mac_acc;
                n_cnt    = (r_cnt == OUT_LAST) ? '0 : r_cnt + 1'b1;
            end
            ST_FOUT_RD: begin
                fs_re = 1'b1;
                b_re  = 1'b1;
            end
            ST_FOUT_PUT, ST_BOUT_PUT: begin
                if (advance) begin
                    out_load = emit;
                    if (r_state == ST_FOUT_PUT) begin
                        fs_we = 1'b1;
                        n_cnt = (r_cnt == OUT_LAST) ? '0 : r_cnt + 1'b1;
                    end else begin
                        ig_we = 1'b1;
                        n_cnt = (r_cnt == IN_LAST) ? '0 : r_cnt + 1'b1;
                    end
                end
            end
            ST_BWD_RD: begin
                w_re     = 1'b1;
                w_raddr  = a_bwd;
                wg_re    = 1'b1;
                wg_raddr = a_bwd;
                ig_re    = 1'b1;
                sv_re    = 1'b1;
            end
            ST_BWD_MUL: begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.op_b   = OPB_W'(x_val);
            end
            ST_BWD_WG: begin
                mac_acc_in     = wg_rd;
                wg_we          = 1'b1;
                wg_waddr       = a_bwd;
                wg_wdata       = mac_acc;
                mac_ctl.mul_en = 1'b1;
            end
            ST_BWD_IG: begin
                mac_acc_in = ig_rd;
                ig_we      = 1'b1;
                ig_wdata   = mac_acc;
                n_cnt      = (r_cnt == IN_LAST) ? '0 : r_cnt + 1'b1;
            end
            ST_BIAS_RD: begin
                bg_re   = 1'b1;
                bg_addr = OW'(r_col);
            end
            ST_BIAS_MUL: begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.op_b   = BIAS_SCALE;
            end
            ST_BIAS_ACC: begin
                mac_acc_in = bg_rd;
                bg_we      = 1'b1;
                bg_addr    = OW'(r_col);
                bg_wdata   = mac_acc;
            end
            ST_BOUT_RD: begin
                ig_re = 1'b1;
            end
            ST_UPD_RD: begin
                w_re  = !r_upd_bias;
                wg_re = !r_upd_bias;
                b_re  = r_upd_bias;
                bg_re = r_upd_bias;
            end
            ST_UPD_LO: begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.op_a   = $signed({2'b00, r_eta});
                mac_ctl.op_b   = $signed({{(OPB_W - LO_BITS){1'b0}}, upd_g[LO_BITS-1:0]});
            end
            ST_UPD_HI: begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.op_a   = $signed({2'b00, r_eta});
                mac_ctl.op_b   = OPB_W'($signed(upd_g[ACC_W-1:LO_BITS]));
            end
            ST_UPD_WR: begin
                if (r_upd_bias) begin
                    b_we    = 1'b1;
                    b_wdata = upd_new;
                    bg_we   = 1'b1;
                    n_cnt   = (r_cnt == BIAS_LAST) ? '0 : r_cnt + 1'b1;
                    if (r_cnt == BIAS_LAST) n_upd_bias = 1'b0;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = upd_new;
                    wg_we   = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    if (r_cnt == ALL_LAST) n_upd_bias = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        out_word.kind        = (r_state == ST_BOUT_PUT) ? KIND_BWD : KIND_FWD;
        out_word.example_res = r_ex;
        out_word.index       = 4'(r_cnt);
        out_word.value_res   = r_res;
        out_word.last        = (r_state == ST_BOUT_PUT) ? (r_cnt == IN_RLAST)
                                                        : (r_cnt == OUT_RLAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_upd_bias  <= 1'b0;
            r_eta       <= 16'd655;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_upd_bias <= n_upd_bias;
            if (i_cfg_we) begin
                r_eta <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ex        <= i_in_word.example;
            r_col       <= i_in_word.col;
            r_val       <= i_in_word.value;
            r_row_end   <= i_in_word.row_end;
            r_batch_end <= i_in_word.batch_end;
        end
        if (out_load) begin
            r_out_word <= out_word;
        end
        case (r_state)
            ST_FOUT_CALC: r_res <= rescale(64'(fs_rd) + (64'(b_rd) <<< FRAC));
            ST_BOUT_CALC: r_res <= rescale(64'(ig_rd));
            ST_UPD_HI:    r_plo <= mac_prod;
            ST_UPD_SUM: begin
                r_delta <= DELTA_W'(((64'(mac_prod) <<< LO_BITS) + 64'(r_plo)
                            + (64'sd1 <<< (UPD_SHIFT - 1))) >>> UPD_SHIFT);
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    dlte_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_acc  (mac_acc_in),
        .o_prod (mac_prod),
        .o_acc  (mac_acc)
    );

    dlte_ram #(.W(VW), .AW(CW)) u_weights (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_re(w_re), .i_raddr(w_raddr), .o_rdata(w_rd)
    );

    dlte_ram #(.W(ACC_W), .AW(CW)) u_weight_grads (
        .i_clk(i_clk), .i_we(wg_we), .i_waddr(wg_waddr), .i_wdata(wg_wdata),
        .i_re(wg_re), .i_raddr(wg_raddr), .o_rdata(wg_rd)
    );

    dlte_ram #(.W(VW), .AW(OW)) u_biases (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_re(b_re), .i_raddr(r_cnt[OW-1:0]), .o_rdata(b_rd)
    );

    dlte_ram #(.W(ACC_W), .AW(OW)) u_bias_grads (
        .i_clk(i_clk), .i_we(bg_we), .i_waddr(bg_addr), .i_wdata(bg_wdata),
        .i_re(bg_re), .i_raddr(bg_addr), .o_rdata(bg_rd)
    );

    dlte_ram #(.W(ACC_W), .AW(OW)) u_fwd_sums (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(r_cnt[OW-1:0]), .i_wdata(fs_wdata),
        .i_re(fs_re), .i_raddr(r_cnt[OW-1:0]), .o_rdata(fs_rd)
    );

    dlte_ram #(.W(ACC_W), .AW(IW)) u_in_grad_sums (
        .i_clk(i_clk), .i_we(ig_we), .i_waddr(r_cnt[IW-1:0]), .i_wdata(ig_wdata),
        .i_re(ig_re), .i_raddr(r_cnt[IW-1:0]), .o_rdata(ig_rd)
    );

    dlte_ram #(.W(VW), .AW(BW + IW)) u_saved_inputs (
        .i_clk(i_clk), .i_we(sv_we), .i_waddr(sv_waddr), .i_wdata(i_in_word.value),
        .i_re(sv_re), .i_raddr(sv_raddr), .o_rdata(sv_rd)
    );

endmodule

### rtl/dlte_ram.sv
// simple dual-port memory, one write and one registered read per cycle
module dlte_ram #(
    parameter int W  = 16,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dlte_mac.sv
// shared multiplier with registered product and saturating accumulate
module dlte_mac import dlte_pkg::*; (
    input  logic     i_clk,
    input  t_mac_ctl i_ctl,
    input  t_acc     i_acc,
    output t_prod    o_prod,
    output t_acc     o_acc
);

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_ctl.op_a * i_ctl.op_b;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = sat_acc(64'(i_acc) + 64'(r_prod));

endmodule

### tb/tb_dense_layer_train_engine_top.sv
// testbench for the dense layer training engine: random forward/backward traffic vs a predictor
`timescale 1ns / 100ps

module tb_dense_layer_train_engine_top import dlte_pkg::*;;

    localparam int N_IN       = 16;
    localparam int N_OUT      = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 1500;

    class layer_scoreboard;
        longint    wt[N_IN][N_OUT];
        longint    bias[N_OUT];
        longint    feat[16][N_IN];
        longint    fwd_acc[N_OUT];
        longint    wt_grad[N_IN][N_OUT];
        longint    bias_grad[N_OUT];
        longint    in_grad[N_IN];
        longint    rate;
        t_out_word expected_words[$];
        int        errors;

        function new();
            foreach (wt[i, j]) begin
                wt[i][j] = 0;
                wt_grad[i][j] = 0;
            end
            foreach (feat[i, j]) feat[i][j] = 0;
            foreach (bias[j]) begin
                bias[j] = 0;
                fwd_acc[j] = 0;
                bias_grad[j] = 0;
            end
            foreach (in_grad[i]) in_grad[i] = 0;
            rate = 655;
            errors = 0;
        endfunction

        function longint clip(longint x, int wd);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (wd - 1)) - 1;
            lo = -hi - 1;
            return x > hi ? hi : (x < lo ? lo : x);
        endfunction

        // add half an lsb, then floor
        function longint round_down(longint x, int s);
            return (x + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint stepped(longint w, longint g);
            return clip(w - round_down(rate * g, 16 + FRAC), VW);
        endfunction

        function void push_row(logic kind, logic [3:0] ex, longint vals[16]);
            t_out_word o;
            for (int k = 0; k < 16; k++) begin
                o.kind        = kind;
                o.example_res = ex;
                o.index       = k[3:0];
                o.value_res   = t_val'(clip(round_down(vals[k], FRAC), VW));
                o.last        = (k == 15);
                expected_words.push_back(o);
            end
        endfunction

        function void note_input(t_in_word iw);
            longint v;
            longint row_vals[16];
            v = longint'(iw.value);
            case (iw.action)
                ACT_LOAD_W: wt[iw.row][iw.col] = v;
                ACT_LOAD_B: bias[iw.col] = v;
                ACT_FWD: begin
                    feat[iw.example][iw.col] = v;
                    for (int j = 0; j < N_OUT; j++)
                        fwd_acc[j] = clip(fwd_acc[j] + v * wt[iw.col][j], ACC_W);
                    if (iw.row_end) begin
                        for (int j = 0; j < N_OUT; j++)
                            row_vals[j] = fwd_acc[j] + bias[j] * (longint'(1) <<< FRAC);
                        push_row(KIND_FWD, iw.example, row_vals);
                        foreach (fwd_acc[j]) fwd_acc[j] = 0;
                    end
                end
                default: begin
                    for (int i = 0; i < N_IN; i++) begin
                        wt_grad[i][iw.col] =
                            clip(wt_grad[i][iw.col] + feat[iw.example][i] * v, ACC_W);
                        in_grad[i] = clip(in_grad[i] + v * wt[i][iw.col], ACC_W);
                    end
                    bias_grad[iw.col] =
                        clip(bias_grad[iw.col] + v * (longint'(1) <<< FRAC), ACC_W);
                    if (iw.row_end) begin
                        foreach (in_grad[i]) row_vals[i] = in_grad[i];
                        push_row(KIND_BWD, iw.example, row_vals);
                        foreach (in_grad[i]) in_grad[i] = 0;
                    end
                    if (iw.batch_end) begin
                        foreach (wt[i, j]) begin
                            wt[i][j] = stepped(wt[i][j], wt_grad[i][j]);
                            wt_grad[i][j] = 0;
                        end
                        foreach (bias[j]) begin
                            bias[j] = stepped(bias[j], bias_grad[j]);
                            bias_grad[j] = 0;
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (expected_words.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            exp_w = expected_words.pop_front();
            if (got.kind !== exp_w.kind) begin
                $error("kind: expected %0d, got %0d", exp_w.kind, got.kind);
                errors++;
            end
            if (got.example_res !== exp_w.example_res) begin
                $error("example_res: expected %0d, got %0d", exp_w.example_res,
                       got.example_res);
                errors++;
            end
            if (got.index !== exp_w.index) begin
                $error("index: expected %0d, got %0d", exp_w.index, got.index);
                errors++;
            end
            if (got.value_res !== exp_w.value_res) begin
                $error("value_res: expected %0d, got %0d", exp_w.value_res, got.value_res);
                errors++;
            end
            if (got.last !== exp_w.last) begin
                $error("last: expected %0d, got %0d", exp_w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_word;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    layer_scoreboard sb;
    logic [15:0]     feat_written[16];
    int              words_sent;
    bit              calm;
    bit              hold_req;
    int              idle_cycles;

    dense_layer_train_engine_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_val rand_value();
        case ($urandom_range(0, 3))
            0: return t_val'($urandom_range(0, 65535));
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return t_val'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send(t_in_word w);
        int gap;
        i_in_valid = 1'b1;
        i_in_word  = w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
        if (w.action == ACT_FWD) feat_written[w.example][w.col] = 1'b1;
        words_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_fields(t_action a, int ex, int r, int c, t_val v, bit re, bit be);
        t_in_word w;
        w.action    = a;
        w.example   = ex[3:0];
        w.row       = r[3:0];
        w.col       = c[3:0];
        w.value     = v;
        w.row_end   = re;
        w.batch_end = be;
        send(w);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.expected_words.size() != 0) @(negedge i_clk);
        // a batch-end update can still be running with nothing left to emit
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_rate(logic [15:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.rate  = val;
    endtask

    task automatic forward_row(int ex, int n);
        for (int c = 0; c < n; c++)
            send_fields(ACT_FWD, ex, $urandom_range(0, 15), (n == 16) ? c : $urandom_range(0, 15),
                        rand_value(), c == n - 1, $urandom_range(0, 1));
    endtask

    task automatic backward_row(int ex, int n, bit be);
        for (int c = 0; c < n; c++)
            send_fields(ACT_BWD, ex, $urandom_range(0, 15), $urandom_range(0, 15),
                        rand_value(), c == n - 1, be && c == n - 1);
    endtask

    function automatic int ready_example();
        int ex;
        ex = $urandom_range(0, 15);
        for (int k = 0; k < 16; k++)
            if (&feat_written[(ex + k) % 16]) return (ex + k) % 16;
        return -1;
    endfunction

    task automatic random_phase(int n_words);
        int stop_at;
        int ex;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: send_fields(ACT_LOAD_W, $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), rand_value(), $urandom_range(0, 1),
                               $urandom_range(0, 1));
                1: send_fields(ACT_LOAD_B, $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), rand_value(), $urandom_range(0, 1),
                               $urandom_range(0, 1));
                2, 3, 4: forward_row($urandom_range(0, 15),
                                     $urandom_range(0, 3) == 0 ? $urandom_range(1, 15) : 16);
                5, 6, 7, 8: begin
                    ex = ready_example();
                    if (ex >= 0)
                        backward_row(ex, $urandom_range(1, 16), $urandom_range(0, 2) == 0);
                end
                default: begin
                    // noise: lone item, odd flags
                    ex = ready_example();
                    if (ex >= 0 && $urandom_range(0, 1))
                        send_fields(ACT_BWD, ex, $urandom_range(0, 15), $urandom_range(0, 15),
                                    rand_value(), $urandom_range(0, 1), $urandom_range(0, 1));
                    else
                        send_fields(ACT_FWD, $urandom_range(0, 15), $urandom_range(0, 15),
                                    $urandom_range(0, 15), rand_value(), $urandom_range(0, 1),
                                    $urandom_range(0, 1));
                end
            endcase
        end
    endtask

    // receiver side
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req    = 1'b0;
                i_out_stall = 1'b1;
                repeat (3000) @(negedge i_clk);
            end else if (calm) begin
                i_out_stall = 1'b0;
            end else if ($urandom_range(0, 149) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end else begin
                i_out_stall = ($urandom_range(0, 99) < 30);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = 16'd0;
        words_sent  = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        foreach (feat_written[e]) feat_written[e] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_rate(16'd65535);

        // directed: extreme weights and biases, one full forward/backward pass
        send_fields(ACT_LOAD_W, 0, 0, 0, 16'sh7fff, 0, 0);
        send_fields(ACT_LOAD_W, 0, 15, 15, 16'sh8000, 0, 0);
        send_fields(ACT_LOAD_B, 0, 0, 0, 16'sh7fff, 0, 0);
        send_fields(ACT_LOAD_B, 0, 0, 15, 16'sh8000, 0, 0);
        for (int c = 0; c < 16; c++)
            send_fields(ACT_FWD, 0, 0, c, c[0] ? 16'sh8000 : 16'sh7fff, c == 15, 0);
        send_fields(ACT_BWD, 0, 0, 0, 16'sh7fff, 0, 0);
        send_fields(ACT_BWD, 0, 0, 15, 16'sh8000, 1, 0);
        // update without a row end
        send_fields(ACT_BWD, 0, 0, 3, 16'sh7fff, 0, 1);
        drain();

        write_rate(16'd0);
        hold_req = 1'b1;
        random_phase(110);
        drain();

        write_rate(16'($urandom_range(0, 65535)));
        calm = 1'b1;
        random_phase(110);
        drain();

        calm = 1'b0;
        write_rate(16'd655);
        random_phase(110);
        drain();

        write_rate(16'd65535);
        random_phase(100);
        drain();

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/dlte_pkg.sv
rtl/dlte_ram.sv
rtl/dlte_mac.sv
rtl/dense_layer_train_engine_top.sv
tb/tb_dense_layer_train_engine_top.sv
